// ===== design/u8sf_pkg.sv =====
// ----------------------------------------------------------------------------
// UTF-8 sanitize filter package
// Transaction types, byte constants and the lead-byte decode shared by the
// filter's modules.
// ----------------------------------------------------------------------------
`default_nettype none

package u8sf_pkg;

  // Byte classes and the bounds of the restricted second bytes.
  localparam logic [7:0] ContMask    = 8'hC0;
  localparam logic [7:0] ContTag     = 8'h80;
  localparam logic [7:0] Lead2Lo     = 8'hC2;
  localparam logic [7:0] Lead2Hi     = 8'hDF;
  localparam logic [7:0] Lead3Lo     = 8'hE0;
  localparam logic [7:0] Lead3Hi     = 8'hEF;
  localparam logic [7:0] Lead4Lo     = 8'hF0;
  localparam logic [7:0] Lead4Hi     = 8'hF4;
  localparam logic [7:0] LeadE0      = 8'hE0;
  localparam logic [7:0] LeadED      = 8'hED;
  localparam logic [7:0] LeadF0      = 8'hF0;
  localparam logic [7:0] LeadF4      = 8'hF4;
  localparam logic [7:0] ContLo      = 8'h80;
  localparam logic [7:0] ContHi      = 8'hBF;
  localparam logic [7:0] SecE0Lo     = 8'hA0;
  localparam logic [7:0] SecEDHi     = 8'h9F;
  localparam logic [7:0] SecF0Lo     = 8'h90;
  localparam logic [7:0] SecF4Hi     = 8'h8F;

  // Number of bytes held while a sequence is unfinished (at most three).
  localparam int unsigned PendDepth  = 3;
  // Results that one input byte can cause.
  localparam int unsigned MaxResults = 4;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_string;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_present;
    logic       last_of_run;
    logic       string_done;
  } out_t;

  // Unfinished sequence held between bytes.
  typedef struct packed {
    logic [PendDepth-1:0][7:0] pend;
    logic [1:0]                cnt;
    logic [2:0]                len;
  } hold_t;

  // Group of results caused by one input byte.
  typedef struct packed {
    logic [MaxResults-1:0][7:0] bytes;
    logic [1:0]                 last_idx;
    logic                       marker;
    logic                       eos;
    logic                       valid;
  } group_t;

  function automatic logic is_cont(input logic [7:0] b);
    return (b & ContMask) == ContTag;
  endfunction

  // Total sequence length for a lead byte, zero when the byte cannot lead.
  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] len;
    len = 3'd0;
    if (b >= Lead2Lo && b <= Lead2Hi) len = 3'd2;
    else if (b >= Lead3Lo && b <= Lead3Hi) len = 3'd3;
    else if (b >= Lead4Lo && b <= Lead4Hi) len = 3'd4;
    return len;
  endfunction

  function automatic logic second_ok(input logic [7:0] lead, input logic [7:0] b);
    logic ok;
    if (lead == LeadE0) ok = (b >= SecE0Lo) && (b <= ContHi);
    else if (lead == LeadED) ok = (b >= ContLo) && (b <= SecEDHi);
    else if (lead == LeadF0) ok = (b >= SecF0Lo) && (b <= ContHi);
    else if (lead == LeadF4) ok = (b >= ContLo) && (b <= SecF4Hi);
    else ok = is_cont(b);
    return ok;
  endfunction

endpackage

`default_nettype wire

// ===== design/utf8_sanitize_filter.sv =====
// ----------------------------------------------------------------------------
// UTF-8 sanitize filter
// Passes on only well-formed UTF-8 sequences of a byte stream, one string at
// a time, and closes every string with a done flag.
// ----------------------------------------------------------------------------
// Usage. The input channel (in_valid_i, in_stall_o, in_data_i) takes one byte
// of a string per transaction, end_of_string set on its final byte. The output
// channel (out_valid_o, out_stall_i, out_data_o) gives one result per
// transaction. A byte releases zero to four results: nothing while a sequence
// is still being gathered, the whole sequence when its last byte arrives, or
// a lone end marker when the final byte releases no data.
// Latency: the first result of a byte is offered in the cycle after the byte
// is accepted. Throughput is set by the output register: it sends one result
// per cycle unless stalled, so a byte that releases n results holds the input
// until its last result leaves; one releasing at most one is taken each cycle.
// A byte that releases nothing is still only taken when the register can load.
// Reset clears the held sequence and empties the output register. When the
// receiver stalls, the offered result holds, and the input stays stalled for
// as long as any result of the current group is still on offer.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_sanitize_filter (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  u8sf_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output u8sf_pkg::out_t out_data_o
);

  // Held sequence. The byte store has no reset: only held entries are read.
  logic [u8sf_pkg::PendDepth-1:0][7:0] pend_q;
  logic [1:0]                          cnt_q;
  logic [2:0]                          len_q;

  // Result group register and the index of the result on offer.
  logic [u8sf_pkg::MaxResults-1:0][7:0] grp_bytes_q;
  logic [1:0]                           grp_last_q;
  logic                                 grp_marker_q;
  logic                                 grp_eos_q;
  logic                                 grp_vld_q;
  logic [1:0]                           idx_q;

  u8sf_pkg::hold_t  hold_cur;
  u8sf_pkg::hold_t  hold_nxt;
  u8sf_pkg::group_t group_nxt;

  logic in_take;
  logic out_take;
  logic grp_last;
  logic grp_free;

  assign hold_cur.pend = pend_q;
  assign hold_cur.cnt  = cnt_q;
  assign hold_cur.len  = len_q;

  u8sf_step u_step (
    .item_i  (in_data_i),
    .hold_i  (hold_cur),
    .hold_o  (hold_nxt),
    .group_o (group_nxt)
  );

  // The group register can load when it is empty or its last result leaves
  // in this cycle.
  assign grp_last = (idx_q == grp_last_q);
  assign out_take = grp_vld_q && !out_stall_i;
  assign grp_free = !grp_vld_q || (out_take && grp_last);
  assign in_stall_o = !grp_free;
  assign in_take  = in_valid_i && grp_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      len_q <= 3'd0;
    end else if (in_take) begin
      cnt_q <= hold_nxt.cnt;
      len_q <= hold_nxt.len;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      pend_q <= hold_nxt.pend;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grp_vld_q <= 1'b0;
      idx_q     <= 2'd0;
    end else if (in_take) begin
      grp_vld_q <= group_nxt.valid;
      idx_q     <= 2'd0;
    end else if (out_take) begin
      if (grp_last) begin
        grp_vld_q <= 1'b0;
      end
      idx_q <= idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      grp_bytes_q  <= group_nxt.bytes;
      grp_last_q   <= group_nxt.last_idx;
      grp_marker_q <= group_nxt.marker;
      grp_eos_q    <= group_nxt.eos;
    end
  end

  assign out_valid_o             = grp_vld_q;
  assign out_data_o.out_byte     = grp_bytes_q[idx_q];
  assign out_data_o.byte_present = !grp_marker_q;
  assign out_data_o.last_of_run  = grp_last;
  assign out_data_o.string_done  = grp_last && grp_eos_q;

endmodule

`default_nettype wire

// ===== design/u8sf_step.sv =====
// ----------------------------------------------------------------------------
// UTF-8 sanitize filter step
// Decides one input byte against the held sequence: the next hold state and
// the group of results that the byte releases.
// ----------------------------------------------------------------------------
`default_nettype none

module u8sf_step (
  input  u8sf_pkg::in_t    item_i,
  input  u8sf_pkg::hold_t  hold_i,
  output u8sf_pkg::hold_t  hold_o,
  output u8sf_pkg::group_t group_o
);

  logic [7:0] b;
  logic       held;
  logic       fits;
  logic [2:0] len;

  assign b    = item_i.in_byte;
  assign held = (hold_i.cnt != 2'd0);
  assign len  = u8sf_pkg::lead_len(b);

  always_comb begin
    if (hold_i.cnt == 2'd1) begin
      fits = u8sf_pkg::second_ok(hold_i.pend[0], b);
    end else begin
      fits = u8sf_pkg::is_cont(b);
    end
  end

  always_comb begin
    hold_o           = hold_i;
    group_o          = '0;
    group_o.bytes    = {b, hold_i.pend};

    if (held && fits) begin
      if (({1'b0, hold_i.cnt} + 3'd1) == hold_i.len) begin
        // Sequence complete: release the held bytes followed by this one.
        group_o.bytes[hold_i.cnt] = b;
        group_o.last_idx          = hold_i.cnt;
        group_o.valid             = 1'b1;
        hold_o.cnt                = 2'd0;
        hold_o.len                = 3'd0;
      end else begin
        hold_o.pend[hold_i.cnt]   = b;
        hold_o.cnt                = hold_i.cnt + 2'd1;
      end
    end else begin
      // Nothing held, or the sequence broke: the byte starts afresh.
      hold_o.cnt = 2'd0;
      hold_o.len = 3'd0;
      if (!b[7]) begin
        group_o.bytes[0] = b;
        group_o.last_idx = 2'd0;
        group_o.valid    = 1'b1;
      end else if (len != 3'd0) begin
        hold_o.pend[0] = b;
        hold_o.cnt     = 2'd1;
        hold_o.len     = len;
      end
    end

    if (item_i.end_of_string) begin
      hold_o.cnt  = 2'd0;
      hold_o.len  = 3'd0;
      group_o.eos = 1'b1;
      if (!group_o.valid) begin
        group_o.bytes[0] = 8'h00;
        group_o.last_idx = 2'd0;
        group_o.marker   = 1'b1;
        group_o.valid    = 1'b1;
      end
    end
  end

endmodule

`default_nettype wire
